// File: rtl/image_convolution_2d_defines.svh
// ----------------------------------------------------------------------------
// image_convolution_2d_defines.svh
// Assertion macros shared by the convolution RTL.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONVOLUTION_2D_DEFINES_SVH
`define IMAGE_CONVOLUTION_2D_DEFINES_SVH

// Clocked check, muted while reset is asserted
`define IC2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication between two conditions
`define IC2D_ASSERT_IMP(lbl, ante, cons, msg) \
  `IC2D_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/ic2d_pkg.sv
// ----------------------------------------------------------------------------
// ic2d_pkg
// Shared types and fixed field widths of the 2D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package ic2d_pkg;

  // Field widths fixed by the item format
  localparam int OP_W       = 2;
  localparam int POS_W      = 8;
  localparam int CH_W       = 2;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;
  localparam int CNT_W      = 3;
  localparam int HALF_W     = 2;
  // Signed offset arithmetic for neighbour coordinates
  localparam int OFS_W      = 14;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 9'd256;
  localparam logic [CNT_W-1:0]  RST_CHANS  = 3'd1;
  localparam logic [HALF_W-1:0] RST_HALF   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TAP = 2'd0,
    OP_LOAD_PIX = 2'd1,
    OP_QUERY    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CHAN_COUNT   = 3'd2,
    CFG_HALF_WIDTH   = 3'd3,
    CFG_HALF_HEIGHT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/ic2d_if.sv
// ----------------------------------------------------------------------------
// ic2d_if
// Valid/ready channels of the convolution block: items, results, registers.
// ----------------------------------------------------------------------------
`default_nettype none

// Input items
interface ic2d_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [ic2d_pkg::OP_W-1:0]        opcode;
  logic        [ic2d_pkg::POS_W-1:0]       pos_x;
  logic        [ic2d_pkg::POS_W-1:0]       pos_y;
  logic        [ic2d_pkg::CH_W-1:0]        channel;
  logic signed [ic2d_pkg::PIX_W-1:0]       pixel_value;
  logic signed [ic2d_pkg::COEF_W-1:0]      coefficient;

  modport source (output valid, opcode, pos_x, pos_y, channel, pixel_value, coefficient,
                  input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, channel, pixel_value, coefficient,
                  output ready);
endinterface

// Result items
interface ic2d_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ic2d_pkg::ACC_W-1:0]   conv_value;
  logic        [ic2d_pkg::POS_W-1:0]   out_x;
  logic        [ic2d_pkg::POS_W-1:0]   out_y;
  logic        [ic2d_pkg::CH_W-1:0]    out_channel;
  logic                                status;

  modport source (output valid, conv_value, out_x, out_y, out_channel, status,
                  input ready);
  modport sink   (input valid, conv_value, out_x, out_y, out_channel, status,
                  output ready);
endinterface

// Register writes
interface ic2d_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ic2d_pkg::CFG_IDX_W-1:0]       index;
  logic [ic2d_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ic2d_ram.sv
// ----------------------------------------------------------------------------
// ic2d_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ic2d_ram #(
  parameter int   WIDTH = 16,
  parameter int   DEPTH = 256,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/ic2d_mac.sv
// ----------------------------------------------------------------------------
// ic2d_mac
// Two-stage multiply-accumulate: registered product, then 40-bit sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ic2d_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ic2d_pkg::mac_ctrl_t                 ctrl_i,
  input  wire logic signed [ic2d_pkg::PIX_W-1:0]   pix_i,
  input  wire logic signed [ic2d_pkg::COEF_W-1:0]  coef_i,
  output logic signed      [ic2d_pkg::ACC_W-1:0]   acc_o,
  output logic                                     busy_o
);

  logic signed [ic2d_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic signed [ic2d_pkg::ACC_W-1:0]  acc_q, acc_d;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.vld && !ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ic2d_pkg::PROD_W'(pix_i) * ic2d_pkg::PROD_W'(coef_i);
  end

  // Accumulate, wrapping at 40 bits
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ic2d_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = ctrl_i.vld || prod_vld_q;

endmodule

`default_nettype wire

// File: rtl/image_convolution_2d.sv
// ----------------------------------------------------------------------------
// image_convolution_2d
// Zero-padded centred 2D convolution over a multi-channel pixel memory,
// one kernel shared by all channels, exact 40-bit fixed-point sum.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                        Role
//  in_chan   in   opcode pos_x pos_y channel pixel_value coeff   tap/pixel load, query
//  out_chan  out  conv_value out_x out_y out_channel status      query result
//  cfg_chan  in   index data                                     register write
//
//  A query is accepted, then reads one memory pair per kernel tap through the
//  single read port of each RAM, then passes the multiply and accumulate
//  stages and the result load. A query outside the image skips the kernel
//  walk. The memories are not cleared after reset; they are valid once
//  written. A stalled result sits in the output register while the next item
//  is taken in.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_convolution_2d_defines.svh"

module image_convolution_2d #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HALF     = 3
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ic2d_in_if.sink   in_chan_i,
  ic2d_out_if.source out_chan_o,
  ic2d_cfg_if.sink  cfg_chan_i
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KSPAN = 2 * MAX_HALF + 1;
  localparam int KW    = (KSPAN > 1) ? $clog2(KSPAN) : 1;
  localparam int PAW   = XW + YW + CW;
  localparam int KAW   = 2 * KW;
  localparam int DW    = ic2d_pkg::DIM_W;
  localparam int NW    = ic2d_pkg::CNT_W;
  localparam int HW    = ic2d_pkg::HALF_W;
  localparam int OW    = ic2d_pkg::OFS_W;

  // Configuration registers
  logic [DW-1:0] cfg_width_q, cfg_height_q;
  logic [NW-1:0] cfg_chans_q;
  logic [HW-1:0] cfg_hw_q, cfg_hh_q;
  logic          cfg_we;

  assign cfg_chan_i.ready = 1'b1;
  assign cfg_we = cfg_chan_i.valid && cfg_chan_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= ic2d_pkg::RST_WIDTH;
      cfg_height_q <= ic2d_pkg::RST_HEIGHT;
      cfg_chans_q  <= ic2d_pkg::RST_CHANS;
      cfg_hw_q     <= ic2d_pkg::RST_HALF;
      cfg_hh_q     <= ic2d_pkg::RST_HALF;
    end else if (cfg_we) begin
      unique case (ic2d_pkg::cfg_idx_e'(cfg_chan_i.index))
        ic2d_pkg::CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_chan_i.data;
        ic2d_pkg::CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_chan_i.data;
        ic2d_pkg::CFG_CHAN_COUNT:   cfg_chans_q  <= NW'(cfg_chan_i.data);
        ic2d_pkg::CFG_HALF_WIDTH:   cfg_hw_q     <= HW'(cfg_chan_i.data);
        ic2d_pkg::CFG_HALF_HEIGHT:  cfg_hh_q     <= HW'(cfg_chan_i.data);
        default: ;
      endcase
    end
  end

  // Registers clipped to the store limits
  logic [DW-1:0] w_eff, h_eff;
  logic [NW-1:0] cc_eff;
  logic [HW-1:0] hw_eff, hh_eff;

  assign w_eff  = (32'(cfg_width_q)  > MAX_WIDTH)    ? DW'(MAX_WIDTH)    : cfg_width_q;
  assign h_eff  = (32'(cfg_height_q) > MAX_HEIGHT)   ? DW'(MAX_HEIGHT)   : cfg_height_q;
  assign cc_eff = (32'(cfg_chans_q)  > MAX_CHANNELS) ? NW'(MAX_CHANNELS) : cfg_chans_q;
  assign hw_eff = (32'(cfg_hw_q)     > MAX_HALF)     ? HW'(MAX_HALF)     : cfg_hw_q;
  assign hh_eff = (32'(cfg_hh_q)     > MAX_HALF)     ? HW'(MAX_HALF)     : cfg_hh_q;

  // Opcode decode of the incoming transaction
  logic in_acc, is_tap, is_pix, is_query;
  logic tap_we, pix_we, q_start, q_oob;

  assign in_acc = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    is_tap   = 1'b0;
    is_pix   = 1'b0;
    is_query = 1'b0;
    unique case (ic2d_pkg::op_e'(in_chan_i.opcode))
      ic2d_pkg::OP_LOAD_TAP: is_tap   = 1'b1;
      ic2d_pkg::OP_LOAD_PIX: is_pix   = 1'b1;
      ic2d_pkg::OP_QUERY:    is_query = 1'b1;
      default: ;
    endcase
  end

  assign tap_we  = in_acc && is_tap && (32'(in_chan_i.pos_x) < KSPAN)
                   && (32'(in_chan_i.pos_y) < KSPAN);
  assign pix_we  = in_acc && is_pix && (32'(in_chan_i.pos_x) < MAX_WIDTH)
                   && (32'(in_chan_i.pos_y) < MAX_HEIGHT)
                   && (32'(in_chan_i.channel) < MAX_CHANNELS);
  assign q_start = in_acc && is_query;
  assign q_oob   = (DW'(in_chan_i.pos_x) >= w_eff) || (DW'(in_chan_i.pos_y) >= h_eff)
                   || (NW'(in_chan_i.channel) >= cc_eff);

  // Query context
  logic [ic2d_pkg::POS_W-1:0] q_x_q, q_y_q;
  logic [ic2d_pkg::CH_W-1:0]  q_c_q;
  logic                       q_oob_q;

  always_ff @(posedge clk_i) begin
    if (q_start) begin
      q_x_q   <= in_chan_i.pos_x;
      q_y_q   <= in_chan_i.pos_y;
      q_c_q   <= in_chan_i.channel;
      q_oob_q <= q_oob;
    end
  end

  // Window walk: neighbour coordinates and padding test
  logic [KW-1:0] di_q, di_d, dj_q, dj_d;
  logic [OW-1:0] xx, yy;
  logic          in_win, last_tap;

  assign xx = OW'(q_x_q) + OW'(di_q) - OW'(hw_eff);
  assign yy = OW'(q_y_q) + OW'(dj_q) - OW'(hh_eff);
  assign in_win = !xx[OW-1] && (xx < OW'(w_eff)) && !yy[OW-1] && (yy < OW'(h_eff));
  assign last_tap = (di_q == KW'({hw_eff, 1'b0})) && (dj_q == KW'({hh_eff, 1'b0}));

  // Memories: pixels at {channel, row, column}, taps at {row, column}
  logic [PAW-1:0]                    pix_waddr, pix_raddr;
  logic [KAW-1:0]                    tap_waddr, tap_raddr;
  logic [ic2d_pkg::PIX_W-1:0]        pix_rdata;
  logic [ic2d_pkg::COEF_W-1:0]       tap_rdata;

  assign pix_waddr = {CW'(in_chan_i.channel), YW'(in_chan_i.pos_y), XW'(in_chan_i.pos_x)};
  assign pix_raddr = {CW'(q_c_q), YW'(yy), XW'(xx)};
  assign tap_waddr = {KW'(in_chan_i.pos_y), KW'(in_chan_i.pos_x)};
  assign tap_raddr = {dj_q, di_q};

  ic2d_ram #(
    .WIDTH (ic2d_pkg::PIX_W),
    .DEPTH (2 ** PAW)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (in_chan_i.pixel_value),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  ic2d_ram #(
    .WIDTH (ic2d_pkg::COEF_W),
    .DEPTH (2 ** KAW)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (in_chan_i.coefficient),
    .raddr_i (tap_raddr),
    .rdata_o (tap_rdata)
  );

  // Sequencer
  ic2d_pkg::state_e    state_q, state_d;
  ic2d_pkg::mac_ctrl_t mac_ctrl;
  logic                rd_vld_q, rd_vld_d;
  logic                mac_busy, slot_free, out_load;
  logic signed [ic2d_pkg::ACC_W-1:0] acc;

  // Items are taken only while no query is in progress
  assign in_chan_i.ready = (state_q == ic2d_pkg::ST_IDLE);

  assign slot_free = !out_chan_o.valid || out_chan_o.ready;

  always_comb begin
    state_d         = state_q;
    di_d            = di_q;
    dj_d            = dj_q;
    rd_vld_d        = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ic2d_pkg::ST_IDLE: begin
        di_d = '0;
        dj_d = '0;
        if (q_start) begin
          state_d = q_oob ? ic2d_pkg::ST_DRAIN : ic2d_pkg::ST_RUN;
        end
      end
      ic2d_pkg::ST_RUN: begin
        rd_vld_d = in_win;
        if (last_tap) begin
          state_d = ic2d_pkg::ST_DRAIN;
        end else if (di_q == KW'({hw_eff, 1'b0})) begin
          di_d = '0;
          dj_d = dj_q + KW'(1);
        end else begin
          di_d = di_q + KW'(1);
        end
      end
      ic2d_pkg::ST_DRAIN: begin
        if (!mac_busy && slot_free) begin
          out_load = 1'b1;
          state_d  = ic2d_pkg::ST_IDLE;
        end
      end
      default: state_d = ic2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ic2d_pkg::ST_IDLE;
      di_q     <= '0;
      dj_q     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      di_q     <= di_d;
      dj_q     <= dj_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Multiply-accumulate on the read data
  assign mac_ctrl.clr = q_start;
  assign mac_ctrl.vld = rd_vld_q;

  ic2d_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .pix_i  (pix_rdata),
    .coef_i (tap_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // Output register
  logic                               out_vld_q, out_vld_d;
  logic signed [ic2d_pkg::ACC_W-1:0]  out_val_q;
  logic [ic2d_pkg::POS_W-1:0]         out_x_q, out_y_q;
  logic [ic2d_pkg::CH_W-1:0]          out_c_q;
  logic                               out_st_q;

  assign out_vld_d = out_load || (out_vld_q && !out_chan_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= q_oob_q ? '0 : acc;
      out_x_q   <= q_x_q;
      out_y_q   <= q_y_q;
      out_c_q   <= q_c_q;
      out_st_q  <= q_oob_q;
    end
  end

  assign out_chan_o.valid       = out_vld_q;
  assign out_chan_o.conv_value  = out_val_q;
  assign out_chan_o.out_x       = out_x_q;
  assign out_chan_o.out_y       = out_y_q;
  assign out_chan_o.out_channel = out_c_q;
  assign out_chan_o.status      = out_st_q;

  // Checks
  `IC2D_ASSERT_IMP(a_write_only_idle, pix_we || tap_we,
                   state_q == ic2d_pkg::ST_IDLE, "memory write while a query runs")
  `IC2D_ASSERT(a_result_from_drain, $rose(out_vld_q) |-> $past(state_q) == ic2d_pkg::ST_DRAIN,
               "result raised outside the drain state")
  `IC2D_ASSERT_IMP(a_oob_zero, out_chan_o.valid && out_chan_o.status,
                   out_chan_o.conv_value == '0, "out-of-image result with non-zero value")
  `IC2D_ASSERT(a_oob_skips_walk, (q_start && q_oob) |=> state_q == ic2d_pkg::ST_DRAIN,
               "out-of-image query walked the kernel")

endmodule

`default_nettype wire

// File: test/conv_result_checker.sv
// ----------------------------------------------------------------------------
// conv_result_checker
// Watches the item, result and register channels of the 2D convolution
// block, keeps its own copy of the kernel, the pixel planes and the
// registers, works out the result of every query and compares each result
// transaction field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module conv_result_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ic2d_in_if        in_mon,
  ic2d_out_if       out_mon,
  ic2d_cfg_if       cfg_mon,
  output int        errors_o,
  output int        pending_o
);
  import ic2d_pkg::*;

  localparam int MAX_DIM   = 256;
  localparam int MAX_CHANS = 4;
  localparam int MAX_HALF  = 3;
  localparam int KSPAN     = 2 * MAX_HALF + 1;
  localparam int PIX_DEPTH = MAX_DIM * MAX_DIM * MAX_CHANS;

  typedef struct packed {
    logic signed [ACC_W-1:0] conv_value;
    logic [POS_W-1:0]        out_x;
    logic [POS_W-1:0]        out_y;
    logic [CH_W-1:0]         out_channel;
    logic                    status;
  } conv_result_t;

  // Shadow of the block's memories and registers
  logic signed [PIX_W-1:0]  pixel_mem [PIX_DEPTH];
  logic signed [COEF_W-1:0] tap_mem [KSPAN*KSPAN];
  logic [DIM_W-1:0]         width_q;
  logic [DIM_W-1:0]         height_q;
  logic [CNT_W-1:0]         chans_q;
  logic [HALF_W-1:0]        half_w_q;
  logic [HALF_W-1:0]        half_h_q;

  // Query results still owed by the block, oldest first
  conv_result_t conv_results_q [$];
  conv_result_t want;

  // Zero-padded sum over the kernel window, registers saturated to the maxima
  function automatic conv_result_t convolve_at(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [CH_W-1:0] c);
    conv_result_t res;
    int w, h, cc, hw, hh, xx, yy, i, j;
    longint acc;
    w  = (int'(width_q) > MAX_DIM) ? MAX_DIM : int'(width_q);
    h  = (int'(height_q) > MAX_DIM) ? MAX_DIM : int'(height_q);
    cc = (int'(chans_q) > MAX_CHANS) ? MAX_CHANS : int'(chans_q);
    hw = int'(half_w_q);
    hh = int'(half_h_q);
    acc = 0;
    res.out_x       = x;
    res.out_y       = y;
    res.out_channel = c;
    res.status      = (int'(x) >= w) || (int'(y) >= h) || (int'(c) >= cc);
    if (!res.status) begin
      for (i = -hw; i <= hw; i++) begin
        xx = int'(x) + i;
        if (xx >= 0 && xx < w) begin
          for (j = -hh; j <= hh; j++) begin
            yy = int'(y) + j;
            if (yy >= 0 && yy < h)
              acc += longint'(tap_mem[(j + hh) * KSPAN + i + hw]) *
                     longint'(pixel_mem[{c, yy[7:0], xx[7:0]}]);
          end
        end
      end
    end
    res.conv_value = acc[ACC_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  // Transactions are sampled at the clock edge; results before items, since
  // a result never answers an item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   = RST_WIDTH;
      height_q  = RST_HEIGHT;
      chans_q   = RST_CHANS;
      half_w_q  = RST_HALF;
      half_h_q  = RST_HALF;
      conv_results_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (conv_results_q.size() == 0) begin
          $display("%0t: result with no query outstanding: value %0d x %0d y %0d ch %0d st %0d",
                   $time, out_mon.conv_value, out_mon.out_x, out_mon.out_y,
                   out_mon.out_channel, out_mon.status);
          errors_o++;
        end else begin
          want = conv_results_q.pop_front();
          check_field("conv_value", longint'(want.conv_value), longint'(out_mon.conv_value));
          check_field("out_x", longint'(want.out_x), longint'(out_mon.out_x));
          check_field("out_y", longint'(want.out_y), longint'(out_mon.out_y));
          check_field("out_channel", longint'(want.out_channel),
                      longint'(out_mon.out_channel));
          check_field("status", longint'(want.status), longint'(out_mon.status));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.opcode)
          OP_LOAD_TAP: begin
            // taps beyond the largest kernel are dropped
            if (int'(in_mon.pos_x) < KSPAN && int'(in_mon.pos_y) < KSPAN)
              tap_mem[int'(in_mon.pos_y) * KSPAN + int'(in_mon.pos_x)] = in_mon.coefficient;
          end
          OP_LOAD_PIX: begin
            // the field widths cover the whole store, so every load lands
            pixel_mem[{in_mon.channel, in_mon.pos_y, in_mon.pos_x}] = in_mon.pixel_value;
          end
          OP_QUERY: conv_results_q.push_back(convolve_at(in_mon.pos_x, in_mon.pos_y,
                                                         in_mon.channel));
          default: ;
        endcase
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_IMAGE_WIDTH:  width_q  = cfg_mon.data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: height_q = cfg_mon.data[DIM_W-1:0];
          CFG_CHAN_COUNT:   chans_q  = cfg_mon.data[CNT_W-1:0];
          CFG_HALF_WIDTH:   half_w_q = cfg_mon.data[HALF_W-1:0];
          CFG_HALF_HEIGHT:  half_h_q = cfg_mon.data[HALF_W-1:0];
          default: ;
        endcase
      end

      pending_o = conv_results_q.size();
    end
  end

endmodule

// File: test/image_convolution_2d_tb.sv
// ----------------------------------------------------------------------------
// image_convolution_2d_tb
// Drives the 2D convolution block with tap loads, pixel loads and queries
// under several register settings and random back-pressure on both sides.
// Every tap and pixel a query reads is loaded beforehand. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module image_convolution_2d_tb;
  import ic2d_pkg::*;

  localparam int MAX_DIM        = 256;
  localparam int MAX_CHANS      = 4;
  localparam int MAX_HALF       = 3;
  localparam int KSPAN          = 2 * MAX_HALF + 1;
  localparam int PIX_DEPTH      = MAX_DIM * MAX_DIM * MAX_CHANS;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int LATENCY_PAD    = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [OP_W-1:0]          OP_UNUSED = 2'd3;
  localparam logic signed [PIX_W-1:0]  PIX_MIN   = 16'sh8000;
  localparam logic signed [PIX_W-1:0]  PIX_MAX   = 16'sh7fff;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 18'sh20000;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 18'sh1ffff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt;
  int   pending;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 51;
  int   stall_cycles  = 0;
  int   items_sent    = 0;

  // Effective register values, used to keep every read on loaded entries
  int img_w  = MAX_DIM;
  int img_h  = MAX_DIM;
  int img_c  = 1;
  int half_w = 1;
  int half_h = 1;
  bit pix_seen [PIX_DEPTH];
  bit tap_seen [KSPAN*KSPAN];

  ic2d_in_if  in_if ();
  ic2d_out_if out_if ();
  ic2d_cfg_if cfg_if ();

  image_convolution_2d u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_chan_i (cfg_if)
  );

  conv_result_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .errors_o  (err_cnt),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [PIX_W-1:0] rand_pix();
    case ($urandom_range(7))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Coordinate inside [0, n), biased towards the borders
  function automatic int pick_coord(input int n);
    if ($urandom_range(9) < 3)
      return ($urandom_range(1) == 0) ? 0 : n - 1;
    return int'($urandom_range(n - 1));
  endfunction

  // One item transaction; valid stays high when items follow back to back
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [CH_W-1:0] c,
                           input logic signed [PIX_W-1:0] pix,
                           input logic signed [COEF_W-1:0] coef);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.pos_x       <= x;
    in_if.pos_y       <= y;
    in_if.channel     <= c;
    in_if.pixel_value <= pix;
    in_if.coefficient <= coef;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic load_tap(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                          input logic signed [COEF_W-1:0] coef);
    send_item(OP_LOAD_TAP, x, y, CH_W'($urandom), rand_pix(), coef);
    if (int'(x) < KSPAN && int'(y) < KSPAN) tap_seen[int'(y) * KSPAN + int'(x)] = 1'b1;
  endtask

  task automatic load_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [CH_W-1:0] c, input logic signed [PIX_W-1:0] pix);
    send_item(OP_LOAD_PIX, x, y, c, pix, rand_coef());
    pix_seen[{c, y, x}] = 1'b1;
  endtask

  // Query, preceded by loads of any tap or neighbour it would read unwritten
  task automatic query_at(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                          input logic [CH_W-1:0] c);
    int xx, yy, i, j;
    if (int'(x) < img_w && int'(y) < img_h && int'(c) < img_c) begin
      for (i = -half_w; i <= half_w; i++) begin
        for (j = -half_h; j <= half_h; j++) begin
          xx = int'(x) + i;
          yy = int'(y) + j;
          if (xx >= 0 && xx < img_w && yy >= 0 && yy < img_h) begin
            if (!tap_seen[(j + half_h) * KSPAN + i + half_w])
              load_tap(POS_W'(i + half_w), POS_W'(j + half_h), rand_coef());
            if (!pix_seen[{c, yy[7:0], xx[7:0]}])
              load_pixel(xx[7:0], yy[7:0], c, rand_pix());
          end
        end
      end
    end
    send_item(OP_QUERY, x, y, c, rand_pix(), rand_coef());
  endtask

  // Sender pause until every query has been answered, then the settle time
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // All five registers; unused upper data bits of the narrow ones get noise
  task automatic write_regs(input int w, input int h, input int c, input int hw,
                            input int hh);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_CHAN_COUNT, {junk[8:3], 3'(c)});
    write_reg(CFG_HALF_WIDTH, {junk[8:2], 2'(hw)});
    write_reg(CFG_HALF_HEIGHT, {junk[6:0], 2'(hh)});
    cfg_if.valid <= 1'b0;
    img_w  = (w > MAX_DIM) ? MAX_DIM : w;
    img_h  = (h > MAX_DIM) ? MAX_DIM : h;
    img_c  = (c > MAX_CHANS) ? MAX_CHANS : c;
    half_w = hw;
    half_h = hh;
  endtask

  // Mostly small images; now and then a large or an empty one
  task automatic pick_settings();
    int kind, which;
    kind  = $urandom_range(9);
    which = $urandom_range(2);
    if (kind == 0)
      write_regs($urandom_range(511, 200), $urandom_range(511, 200), $urandom_range(7, 1),
                 $urandom_range(3), $urandom_range(3));
    else if (kind == 1)
      write_regs((which == 0) ? 0 : 5, (which == 1) ? 0 : 5, (which == 2) ? 0 : 2, 1, 1);
    else
      write_regs($urandom_range(12, 1), $urandom_range(12, 1), $urandom_range(7, 1),
                 $urandom_range(3), $urandom_range(3));
  endtask

  // Mostly inside the image in use, otherwise anywhere the fields reach
  task automatic pick_position(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y,
                               output logic [CH_W-1:0] c);
    if (img_w > 0 && img_h > 0 && img_c > 0 && $urandom_range(99) < 85) begin
      x = POS_W'(pick_coord(img_w));
      y = POS_W'(pick_coord(img_h));
      c = CH_W'($urandom_range(img_c - 1));
    end else begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
      c = CH_W'($urandom);
    end
  endtask

  task automatic random_step();
    int r;
    logic [POS_W-1:0] x, y;
    logic [CH_W-1:0]  c;
    r = $urandom_range(99);
    pick_position(x, y, c);
    if (r < 55)
      query_at(x, y, c);
    else if (r < 73)
      load_pixel(x, y, c, rand_pix());
    else if (r < 85) begin
      if ($urandom_range(4) == 0)
        load_tap(POS_W'($urandom), POS_W'($urandom), rand_coef());
      else
        load_tap(POS_W'($urandom_range(KSPAN - 1)), POS_W'($urandom_range(KSPAN - 1)),
                 rand_coef());
    end else if (r < 90)
      send_item(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), CH_W'($urandom), rand_pix(),
                rand_coef());
    else if (r < 92)
      drain_results();
    else begin
      // the same query twice, around a tap update
      query_at(x, y, c);
      load_tap(POS_W'($urandom_range(KSPAN - 1)), POS_W'($urandom_range(KSPAN - 1)),
               rand_coef());
      query_at(x, y, c);
    end
  endtask

  initial begin
    int phase, target;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_LOAD_TAP;
    in_if.pos_x       = '0;
    in_if.pos_y       = '0;
    in_if.channel     = '0;
    in_if.pixel_value = '0;
    in_if.coefficient = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_IMAGE_WIDTH;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes, dropped loads, unused opcode
    load_tap(0, 0, COEF_MIN);
    load_tap(POS_W'(KSPAN - 1), POS_W'(KSPAN - 1), COEF_MAX);
    load_tap(POS_W'(KSPAN), 3, rand_coef());
    load_tap(2, 255, rand_coef());
    send_item(OP_UNUSED, 255, 255, 3, PIX_MAX, COEF_MAX);
    load_pixel(0, 0, 0, PIX_MIN);
    load_pixel(255, 255, 3, PIX_MAX);
    query_at(0, 0, 0);
    query_at(255, 255, 3);
    query_at(255, 255, 0);
    query_at(0, 0, 3);

    // Oversized registers saturate; widest kernel
    drain_results();
    write_regs(511, 511, 7, 3, 3);
    query_at(255, 255, 3);
    query_at(128, 0, 2);

    // Empty image
    drain_results();
    write_regs(0, 256, 4, 0, 0);
    query_at(0, 0, 0);

    // Single pixel, single tap: the two minimum values multiplied
    drain_results();
    write_regs(1, 1, 1, 0, 0);
    query_at(0, 0, 0);
    query_at(1, 0, 0);

    // Random phases under three back-pressure patterns
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 20;
      end else if (phase == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      pick_settings();
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_step();
    end

    drain_results();
    if (pending != 0)
      $display("%0t: %0d query results never arrived", $time, pending);
    if (err_cnt == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
